// ----- sv/chm_pkg.sv -----
// Shared types and codes for the chained hash map engine.
// No dependencies; the engine, chm_mod and the testbench use it by scoped names.
package chm_pkg;

    typedef logic [1:0] t_func;
    localparam t_func FUNC_INSERT = 2'd0;
    localparam t_func FUNC_GET    = 2'd1;
    localparam t_func FUNC_REMOVE = 2'd2;
    localparam t_func FUNC_NONE   = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_MISSING = 2'd1;
    localparam t_status ST_FULL    = 2'd2;

    localparam int KeyWidth   = 64;
    localparam int ValueWidth = 64;

    typedef struct packed {
        t_func                 func;
        logic [KeyWidth-1:0]   key;
        logic [ValueWidth-1:0] value;
    } t_in_word;

    typedef struct packed {
        t_status               status;
        logic [ValueWidth-1:0] found_value;
    } t_out_word;

endpackage

// ----- sv/chained_hash_map_engine.sv -----
// Chained hash map engine: top level with the operation sequencer.
// Depends on chm_pkg, chm_ram and chm_mod.
//
// Maps 64-bit keys to 64-bit values in a hash table with separate chaining.
// Each word on the input channel is one operation (insert, get, remove);
// each produces exactly one output word with a status and, for a hit on a
// get, the value of the newest matching entry. Inserts push at the head of
// the key's bucket, so duplicates shadow older entries; a remove unlinks the
// newest match and returns its node to the free list. An insert with no
// free node is dropped with status "full". After reset the block runs a
// clearing pass, writing empty bucket heads and linking the free list,
// before it takes its first word. Timing: one operation at a time. After
// the accept, the bucket index comes from the shared modulo unit (eight
// key bits per cycle over 8 steps, then the result is registered), then
// the bucket head is read in S_HEAD and S_HEADQ. An insert then writes in
// S_INS; a get or remove visits each chain node in S_WALK and S_CHK
// through the registered node RAM read port (S_WALK also sees the chain
// end on a miss; a remove unlinks in S_CHK and frees the node in S_REM),
// and S_RESP posts the result, held while a previous output word waits
// unaccepted. An unused operation code goes straight to S_RESP and
// changes nothing.
module chained_hash_map_engine #(
    parameter int BUCKET_COUNT = 64,
    parameter int POOL_NODES   = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  chm_pkg::t_in_word i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output chm_pkg::t_out_word o_out_data
);
    localparam int NW = $clog2(POOL_NODES + 1);
    localparam int AW = $clog2(POOL_NODES);
    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int INIT_LEN = (BUCKET_COUNT > POOL_NODES) ? BUCKET_COUNT : POOL_NODES;
    localparam int IW = (INIT_LEN > 1) ? $clog2(INIT_LEN) : 1;
    localparam logic [NW-1:0] NIL = NW'(POOL_NODES);
    localparam int KW = chm_pkg::KeyWidth;
    localparam int VW = chm_pkg::ValueWidth;

    typedef enum logic [9:0] {
        S_INIT  = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_HASH  = 10'b00_0000_0100,
        S_HEAD  = 10'b00_0000_1000,
        S_HEADQ = 10'b00_0001_0000,
        S_INS   = 10'b00_0010_0000,
        S_WALK  = 10'b00_0100_0000,
        S_CHK   = 10'b00_1000_0000,
        S_REM   = 10'b01_0000_0000,
        S_RESP  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Operation context
    chm_pkg::t_in_word  r_in, n_in;
    logic [BW-1:0]      r_bucket, n_bucket;
    logic [NW-1:0]      r_cur, n_cur;
    logic [NW-1:0]      r_prev, n_prev;
    logic [NW-1:0]      r_steps, n_steps;
    logic [NW-1:0]      r_free, n_free;
    logic [IW-1:0]      r_init, n_init;
    chm_pkg::t_status   r_status, n_status;
    logic [VW-1:0]      r_found, n_found;

    // Output register
    logic               r_out_valid, n_out_valid;
    chm_pkg::t_out_word r_out, n_out;

    // Modulo unit
    logic          w_mod_start;
    logic          w_mod_done;
    logic [BW-1:0] w_mod_bucket;

    // Memory ports
    logic          w_head_we;
    logic [BW-1:0] w_head_waddr;
    logic [NW-1:0] w_head_wdata;
    logic [NW-1:0] w_head_q;

    logic          w_next_we;
    logic [AW-1:0] w_next_waddr;
    logic [NW-1:0] w_next_wdata;
    logic [NW-1:0] w_next_q;

    logic          w_kv_we;
    logic [KW+VW-1:0] w_kv_q;

    logic [AW-1:0] w_node_raddr;
    logic          w_accept;
    logic          w_init_bucket;
    logic          w_init_node;
    logic          w_key_hit;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_mod_start = w_accept && (i_in_data.func == chm_pkg::FUNC_INSERT
                                   || i_in_data.func == chm_pkg::FUNC_GET
                                   || i_in_data.func == chm_pkg::FUNC_REMOVE);

    assign w_init_bucket = ({1'b0, r_init} < (IW+1)'(BUCKET_COUNT));
    assign w_init_node   = ({1'b0, r_init} < (IW+1)'(POOL_NODES));

    // Walk reads the current node; an insert reads the free-list head.
    assign w_node_raddr = (r_state == S_WALK) ? r_cur[AW-1:0] : r_free[AW-1:0];
    assign w_key_hit    = (w_kv_q[KW+VW-1:VW] == r_in.key);

    chm_mod #(.BUCKET_COUNT(BUCKET_COUNT)) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mod_start),
        .i_key    (i_in_data.key),
        .o_done   (w_mod_done),
        .o_bucket (w_mod_bucket)
    );

    chm_ram #(.WIDTH(NW), .DEPTH(BUCKET_COUNT)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_head_we),
        .i_waddr (w_head_waddr),
        .i_wdata (w_head_wdata),
        .i_raddr (r_bucket),
        .o_rdata (w_head_q)
    );

    chm_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_next_waddr),
        .i_wdata (w_next_wdata),
        .i_raddr (w_node_raddr),
        .o_rdata (w_next_q)
    );

    chm_ram #(.WIDTH(KW+VW), .DEPTH(POOL_NODES)) u_kv_ram (
        .i_clk   (i_clk),
        .i_we    (w_kv_we),
        .i_waddr (r_free[AW-1:0]),
        .i_wdata ({r_in.key, r_in.value}),
        .i_raddr (w_node_raddr),
        .o_rdata (w_kv_q)
    );

    // Memory write steering
    always_comb begin
        w_head_we    = 1'b0;
        w_head_waddr = r_bucket;
        w_head_wdata = r_free;
        w_next_we    = 1'b0;
        w_next_waddr = r_free[AW-1:0];
        w_next_wdata = r_cur;
        w_kv_we      = 1'b0;
        unique case (r_state)
            S_INIT: begin
                // Clear bucket heads and chain the pool: node i -> i+1.
                w_head_we    = w_init_bucket;
                w_head_waddr = r_init[BW-1:0];
                w_head_wdata = NIL;
                w_next_we    = w_init_node;
                w_next_waddr = r_init[AW-1:0];
                w_next_wdata = NW'({1'b0, r_init} + 1'b1);
            end
            S_INS: begin
                // Push the free node at the bucket head.
                w_head_we = 1'b1;
                w_next_we = 1'b1;
                w_kv_we   = 1'b1;
            end
            S_CHK: begin
                // Unlink the match from its predecessor or the bucket head.
                if (w_key_hit && r_in.func == chm_pkg::FUNC_REMOVE) begin
                    if (r_prev != NIL) begin
                        w_next_we    = 1'b1;
                        w_next_waddr = r_prev[AW-1:0];
                        w_next_wdata = w_next_q;
                    end else begin
                        w_head_we    = 1'b1;
                        w_head_wdata = w_next_q;
                    end
                end
            end
            S_REM: begin
                // Return the node to the free list.
                w_next_we    = 1'b1;
                w_next_waddr = r_cur[AW-1:0];
                w_next_wdata = r_free;
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_bucket    = r_bucket;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_steps     = r_steps;
        n_free      = r_free;
        n_init      = r_init;
        n_status    = r_status;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                n_init = r_init + 1'b1;
                if (r_init == IW'(INIT_LEN - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_in     = i_in_data;
                    n_found  = '0;
                    n_status = chm_pkg::ST_DONE;
                    n_state  = w_mod_start ? S_HASH : S_RESP;
                end
            end
            S_HASH: begin
                if (w_mod_done) begin
                    n_bucket = w_mod_bucket;
                    n_state  = S_HEAD;
                end
            end
            S_HEAD: begin
                n_state = S_HEADQ;
            end
            S_HEADQ: begin
                n_cur   = w_head_q;
                n_prev  = NIL;
                n_steps = '0;
                if (r_in.func == chm_pkg::FUNC_INSERT) begin
                    if (r_free == NIL) begin
                        n_status = chm_pkg::ST_FULL;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_INS;
                    end
                end else begin
                    n_state = S_WALK;
                end
            end
            S_INS: begin
                n_free  = w_next_q;
                n_state = S_RESP;
            end
            S_WALK: begin
                if (r_cur == NIL || r_steps == NIL) begin
                    n_status = chm_pkg::ST_MISSING;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (w_key_hit) begin
                    if (r_in.func == chm_pkg::FUNC_GET) begin
                        n_found = w_kv_q[VW-1:0];
                        n_state = S_RESP;
                    end else begin
                        n_state = S_REM;
                    end
                end else begin
                    n_prev  = r_cur;
                    n_cur   = w_next_q;
                    n_steps = r_steps + 1'b1;
                    n_state = S_WALK;
                end
            end
            S_REM: begin
                n_free  = r_cur;
                n_state = S_RESP;
            end
            S_RESP: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.found_value = r_found;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init      <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
        r_in     <= n_in;
        r_bucket <= n_bucket;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_steps  <= n_steps;
        r_status <= n_status;
        r_found  <= n_found;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // The free-list head is a node or null, never beyond.
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= NIL)
        else $error("free-list head out of range");

    // An accepted word drops ready on the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("ready stayed high after accept");

    // No word is taken during the clearing pass.
    a_no_accept_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_in_ready)
        else $error("ready during clearing pass");

    // A result is only posted into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("pending output word overwritten");
`endif
endmodule

// ----- sv/chm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/chm_mod.sv -----
// Iterative key-modulo-bucket-count unit: eight key bits per cycle,
// shift in a bit and conditionally subtract. Depends on chm_pkg.
module chm_mod #(
    parameter int BUCKET_COUNT = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [chm_pkg::KeyWidth-1:0]       i_key,
    output logic                               o_done,
    output logic [(BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1)-1:0] o_bucket
);
    localparam int RW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam logic [RW:0] BC = (RW+1)'(BUCKET_COUNT);
    localparam int BitsPerStep = 8;
    localparam int Steps = chm_pkg::KeyWidth / BitsPerStep;
    localparam int CW = $clog2(Steps);

    logic [chm_pkg::KeyWidth-1:0] r_key, n_key;
    logic [RW-1:0]                r_rem, n_rem;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic                         r_busy, n_busy;
    logic                         r_done, n_done;

    always_comb begin
        logic [RW:0] t;
        t      = '0;
        n_key  = r_key;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_key  = i_key;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            t = {1'b0, r_rem};
            for (int b = 0; b < BitsPerStep; b++) begin
                t = {t[RW-1:0], r_key[chm_pkg::KeyWidth-1-b]};
                if (t >= BC) begin
                    t = t - BC;
                end
            end
            n_rem = t[RW-1:0];
            n_key = r_key << BitsPerStep;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(Steps - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_key <= n_key;
        r_rem <= n_rem;
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem;
endmodule

// ----- tb/sv/chained_hash_map_engine_test.sv -----
// Self-checking testbench for the chained hash map engine.
// Depends on chm_pkg and the chained_hash_map_engine RTL; keeps its own map model.
module chained_hash_map_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUCKETS = 64;
    localparam int NODES   = 256;
    localparam int NIL     = NODES;
    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    chm_pkg::t_in_word  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    chm_pkg::t_out_word o_out_data;

    chained_hash_map_engine #(.BUCKET_COUNT(BUCKETS), .POOL_NODES(NODES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Map model: same chaining and free-list order as the engine.
    int unsigned       head_of_bucket[BUCKETS];
    logic [63:0]       entry_key[NODES];
    logic [63:0]       entry_value[NODES];
    int unsigned       entry_next[NODES];
    int unsigned       free_top;

    chm_pkg::t_in_word  pending_ops[$];
    chm_pkg::t_out_word expected_words[$];
    logic [63:0] live_keys[$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        stimulus_done = 1'b0;
    bit        calm_phase = 1'b0;

    function automatic void clear_map();
        for (int b = 0; b < BUCKETS; b++) head_of_bucket[b] = NIL;
        for (int n = 0; n < NODES; n++) begin
            entry_next[n] = n + 1;
            entry_key[n] = '0;
            entry_value[n] = '0;
        end
        free_top = 0;
    endfunction

    function automatic chm_pkg::t_out_word apply_map_op(chm_pkg::t_in_word op);
        chm_pkg::t_out_word res;
        int unsigned b, n, prev, steps;
        res = '0;
        res.status = chm_pkg::ST_DONE;
        b = 32'(op.key % 64'(BUCKETS));
        case (op.func)
            chm_pkg::FUNC_INSERT: begin
                n = free_top;
                if (n >= NODES) begin
                    res.status = chm_pkg::ST_FULL;
                end else begin
                    free_top = entry_next[n];
                    entry_key[n] = op.key;
                    entry_value[n] = op.value;
                    entry_next[n] = head_of_bucket[b];
                    head_of_bucket[b] = n;
                end
            end
            chm_pkg::FUNC_GET, chm_pkg::FUNC_REMOVE: begin
                res.status = chm_pkg::ST_MISSING;
                prev = NIL;
                n = head_of_bucket[b];
                steps = 0;
                while (n < NODES && steps < NODES) begin
                    if (entry_key[n] == op.key) begin
                        res.status = chm_pkg::ST_DONE;
                        if (op.func == chm_pkg::FUNC_GET) begin
                            res.found_value = entry_value[n];
                        end else begin
                            if (prev < NODES) entry_next[prev] = entry_next[n];
                            else head_of_bucket[b] = entry_next[n];
                            entry_next[n] = free_top;
                            free_top = n;
                        end
                        break;
                    end
                    prev = n;
                    n = entry_next[n];
                    steps++;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic chm_pkg::t_in_word make_op(chm_pkg::t_func f, logic [63:0] k,
                                                  logic [63:0] v);
        chm_pkg::t_in_word w;
        w.func = f;
        w.key = k;
        w.value = v;
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Pick a key: mostly one already inserted, sometimes one from a small range or fresh.
    function automatic logic [63:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (live_keys.size() > 0 && sel < 6)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        if (sel < 8)
            return {54'($urandom_range(0, 3)), 10'($urandom_range(0, 1023))};
        return rand64();
    endfunction

    initial begin
        logic [63:0] k;
        // Extremes of key and value, every operation, unused code.
        pending_ops.push_back(make_op(chm_pkg::FUNC_GET, '0, '0));
        pending_ops.push_back(make_op(chm_pkg::FUNC_REMOVE, '1, '0));
        pending_ops.push_back(make_op(chm_pkg::FUNC_INSERT, '0, '1));
        pending_ops.push_back(make_op(chm_pkg::FUNC_INSERT, '1, '0));
        pending_ops.push_back(make_op(chm_pkg::FUNC_INSERT, 64'd64, 64'h5555_5555_5555_5555));
        pending_ops.push_back(make_op(chm_pkg::FUNC_INSERT, '0, 64'hAAAA_AAAA_AAAA_AAAA));
        pending_ops.push_back(make_op(chm_pkg::FUNC_GET, '0, '1));
        pending_ops.push_back(make_op(chm_pkg::FUNC_GET, 64'd64, '0));
        pending_ops.push_back(make_op(chm_pkg::FUNC_GET, 64'd128, '0));
        pending_ops.push_back(make_op(chm_pkg::FUNC_GET, '1, '0));
        pending_ops.push_back(make_op(chm_pkg::FUNC_NONE, '1, '1));
        // Remove from the middle of a chain, then the newest duplicate.
        pending_ops.push_back(make_op(chm_pkg::FUNC_REMOVE, 64'd64, '0));
        pending_ops.push_back(make_op(chm_pkg::FUNC_REMOVE, '0, '0));
        pending_ops.push_back(make_op(chm_pkg::FUNC_GET, '0, '0));
        pending_ops.push_back(make_op(chm_pkg::FUNC_REMOVE, '0, '0));
        pending_ops.push_back(make_op(chm_pkg::FUNC_GET, '0, '0));
        pending_ops.push_back(make_op(chm_pkg::FUNC_REMOVE, '1, '0));
        pending_ops.push_back(make_op(chm_pkg::FUNC_GET, '1, '0));

        // Random mix, then a phase that fills the pool to overflow, then random mix again.
        for (int r = 0; r < 550; r++) begin
            int sel;
            sel = $urandom_range(0, 99);
            if (r >= 100 && r < 420) begin
                // Filling phase: enough inserts to overrun the pool.
                k = (sel < 85) ? pick_key() : rand64();
                if (sel < 88) begin
                    pending_ops.push_back(make_op(chm_pkg::FUNC_INSERT, k, rand64()));
                    live_keys.push_back(k);
                end else begin
                    pending_ops.push_back(make_op(chm_pkg::FUNC_GET, k, rand64()));
                end
                continue;
            end
            k = pick_key();
            if (sel < 35) begin
                pending_ops.push_back(make_op(chm_pkg::FUNC_INSERT, k, rand64()));
                live_keys.push_back(k);
            end else if (sel < 65) begin
                pending_ops.push_back(make_op(chm_pkg::FUNC_GET, k, rand64()));
            end else if (sel < 97) begin
                pending_ops.push_back(make_op(chm_pkg::FUNC_REMOVE, k, rand64()));
            end else begin
                pending_ops.push_back(make_op(chm_pkg::FUNC_NONE, k, rand64()));
            end
        end
    end

    // Driver: hold a word until accepted, idle at random outside calm stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                expected_words.push_back(apply_map_op(i_in_data));
            end
            if (pending_ops.size() > 0 && (calm_phase || $urandom_range(0, 99) >= 18)) begin
                i_in_data <= pending_ops.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
                if (pending_ops.size() == 0) stimulus_done <= 1'b1;
            end
        end
    end

    // Monitor: compare each accepted output word with the oldest prediction.
    always @(posedge i_clk) begin
        chm_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", o_out_data.found_value, '0);
            end else begin
                want = expected_words.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", 64'(o_out_data.status), 64'(want.status));
                if (o_out_data.found_value !== want.found_value)
                    report_mismatch("found_value", o_out_data.found_value,
                                    want.found_value);
            end
        end
        i_out_ready <= calm_phase || ($urandom_range(0, 99) >= 18);
    end

    // Cycle counter; it also sets a calm stretch in which neither side idles.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        calm_phase <= (cycle_count >= 3000 && cycle_count < 6000);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        clear_map();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Wait for every word to go in and come back, then drain a while.
        wait (stimulus_done && !i_in_valid && expected_words.size() == 0);
        repeat (600) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
